[src/qte_pkg.sv]
// Shared constants and helper functions for the quaternion-to-Euler block.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
package qte_pkg;

   localparam int QUAT_W           = 16;
   localparam int QUAT_FRAC_BITS   = 14;
   localparam int DEF_CORDIC_STEPS = 14;
   localparam int TABLE_LEN        = 24;
   localparam int MARGIN_W         = 11;
   localparam int ROLL_W           = 15;
   localparam int PITCH_W          = 14;
   localparam int YAW_W            = 16;

   // internal angle: 2^-30 rad units
   localparam int ANG_W     = 36;
   localparam int Q12_SHIFT = 18;
   localparam int Q12_W     = ANG_W - Q12_SHIFT;
   localparam int PROD_W    = 2 * QUAT_W;
   localparam int ARG_W     = PROD_W + 4;
   localparam int XY_W      = ARG_W + 2;
   localparam int S_W       = 32;
   localparam int SF_W      = ARG_W + 8;

   // square root of a value up to 2^60
   localparam int SQ_N_W      = 61;
   localparam int SQ_R_W      = 62;
   localparam int ROOT_W      = 31;
   localparam int SQRT_STAGES = 31;

   // scaling of the asin argument to 30 fraction bits
   localparam int SCALE_UP = (2 * QUAT_FRAC_BITS >= 30) ? 0 : 30 - 2 * QUAT_FRAC_BITS;
   localparam int SCALE_DN = (2 * QUAT_FRAC_BITS >= 30) ? 2 * QUAT_FRAC_BITS - 30 : 0;

   localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
   localparam int HALF_PI_Q12 = 6434;

   // atan(2^-i) in 2^-30 rad, truncated
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         0:       v = 36'sd843314856;
         1:       v = 36'sd497837829;
         2:       v = 36'sd263043836;
         3:       v = 36'sd133525158;
         4:       v = 36'sd67021686;
         5:       v = 36'sd33543515;
         6:       v = 36'sd16775850;
         7:       v = 36'sd8388437;
         8:       v = 36'sd4194282;
         9:       v = 36'sd2097149;
         10:      v = 36'sd1048575;
         11:      v = 36'sd524287;
         12:      v = 36'sd262143;
         13:      v = 36'sd131071;
         14:      v = 36'sd65535;
         15:      v = 36'sd32767;
         16:      v = 36'sd16383;
         17:      v = 36'sd8191;
         18:      v = 36'sd4095;
         19:      v = 36'sd2047;
         20:      v = 36'sd1023;
         21:      v = 36'sd511;
         22:      v = 36'sd255;
         23:      v = 36'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   // round an internal angle to Q5.12: floor((a + 2^17) / 2^18)
   function automatic logic signed [Q12_W-1:0] to_q12(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W-1:0] t;
      t = a + (ANG_W'(1) <<< (Q12_SHIFT - 1));
      return t[ANG_W-1:Q12_SHIFT];
   endfunction

endpackage

[src/qte_isqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on qte_pkg; carries a side payload alongside the root.
`timescale 1ns / 1ps
module qte_isqrt import qte_pkg::*; #(
   parameter int SIDE_W = S_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SQ_N_W-1:0]   n_in,
   input  logic [SIDE_W-1:0]   side_in,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   root_out,
   output logic [SIDE_W-1:0]   side_out
);

   logic [SQ_R_W-1:0] rem_ff  [0:SQRT_STAGES-1];
   logic [SQ_R_W-1:0] res_ff  [0:SQRT_STAGES-1];
   logic [SIDE_W-1:0] side_ff [0:SQRT_STAGES-1];
   logic              vld_ff  [0:SQRT_STAGES-1];

   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
      localparam logic [SQ_R_W-1:0] BIT = SQ_R_W'(1) << (2 * (SQRT_STAGES - 1 - j));
      logic [SQ_R_W-1:0] rem_prev, res_prev, trial, rem_in, res_in;
      logic [SIDE_W-1:0] side_prev;
      logic              vld_prev;

      if (j == 0) begin : g_first
         assign rem_prev  = SQ_R_W'(n_in);
         assign res_prev  = '0;
         assign side_prev = side_in;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign res_prev  = res_ff[j-1];
         assign side_prev = side_ff[j-1];
         assign vld_prev  = vld_ff[j-1];
      end

      // try to subtract the next root bit
      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            res_ff[j]  <= res_in;
            side_ff[j] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign root_out  = res_ff[SQRT_STAGES-1][ROOT_W-1:0];
   assign side_out  = side_ff[SQRT_STAGES-1];

endmodule

[src/qte_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x), one iteration per register stage.
// Depends on qte_pkg for the arctangent table and angle constants.
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; #(
   parameter int STEPS = DEF_CORDIC_STEPS
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [XY_W-1:0]  y_in,
   input  logic signed [XY_W-1:0]  x_in,
   output logic signed [ANG_W-1:0] z_out
);

   logic signed [XY_W-1:0]  x_ff  [0:STEPS];
   logic signed [XY_W-1:0]  y_ff  [0:STEPS];
   logic signed [ANG_W-1:0] z_ff  [0:STEPS];
   logic signed [ANG_W-1:0] fz_ff [0:STEPS];
   logic                    fix_ff[0:STEPS];

   logic signed [XY_W-1:0]  x0_in, y0_in;
   logic signed [ANG_W-1:0] z0_in, fz0_in;
   logic                    fix0_in;

   // handle axis cases and pre-rotate the left half plane
   always_comb begin
      x0_in   = x_in;
      y0_in   = y_in;
      z0_in   = '0;
      fix0_in = 1'b0;
      fz0_in  = '0;
      if (y_in == '0) begin
         fix0_in = 1'b1;
         fz0_in  = (x_in < 0) ? ANG_PI : '0;
      end else if (x_in == '0) begin
         fix0_in = 1'b1;
         fz0_in  = (y_in > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
      end
      if (x_in < 0) begin
         if (y_in > 0) begin
            x0_in = y_in;
            y0_in = -x_in;
            z0_in = ANG_HALF_PI;
         end else begin
            x0_in = -y_in;
            y0_in = x_in;
            z0_in = -ANG_HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= x0_in;
         y_ff[0]   <= y0_in;
         z_ff[0]   <= z0_in;
         fz_ff[0]  <= fz0_in;
         fix_ff[0] <= fix0_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      logic signed [XY_W-1:0]  xs, ys, x_in_k, y_in_k;
      logic signed [ANG_W-1:0] z_in_k;

      // rotate toward the x axis
      always_comb begin
         xs = x_ff[k] >>> k;
         ys = y_ff[k] >>> k;
         if (y_ff[k] > 0) begin
            x_in_k = x_ff[k] + ys;
            y_in_k = y_ff[k] - xs;
            z_in_k = z_ff[k] + atan_entry(k);
         end else begin
            x_in_k = x_ff[k] - ys;
            y_in_k = y_ff[k] + xs;
            z_in_k = z_ff[k] - atan_entry(k);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]   <= x_in_k;
            y_ff[k+1]   <= y_in_k;
            z_ff[k+1]   <= z_in_k;
            fz_ff[k+1]  <= fz_ff[k];
            fix_ff[k+1] <= fix_ff[k];
         end
      end
   end

   assign z_out = fix_ff[STEPS] ? fz_ff[STEPS] : z_ff[STEPS];

endmodule

[src/quaternion_to_euler_top.sv]
// Top level of the quaternion-to-Euler converter: front stages, branch select, output.
// Depends on qte_pkg, qte_isqrt and qte_cordic.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one quaternion (Q1.14) per transaction; rsp_* returns roll,
//   pitch, yaw (Q2.12, Q1.12, Q3.12 rad) and the gimbal-lock flag, one transaction per input.
//   csr_gimbal_margin sets the singular-branch margin; csr_ready is always high
//   and the register should only be written while the block is empty.
// Pipeline: from acceptance to rsp_valid a transaction passes three
//   product/sum/square stages, 31 square-root stages, one pre-rotation
//   plus one stage per CORDIC iteration, the branch select stage and
//   the output register.
// Throughput: one transaction per cycle unless stalled; every stage is a
//   plain register and the roll/yaw CORDICs run in parallel with the pitch path.
// Reset: synchronous, active high; clears all valid bits and the margin
//   register to zero.
// Stall: while rsp_valid is high and rsp_ready is low the whole pipeline
//   holds and req_ready drops; nothing is lost or repeated.
module quaternion_to_euler_top import qte_pkg::*; #(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [QUAT_W-1:0] req_quat_x,
   input  logic signed [QUAT_W-1:0] req_quat_y,
   input  logic signed [QUAT_W-1:0] req_quat_z,
   input  logic signed [QUAT_W-1:0] req_quat_w,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ROLL_W-1:0] rsp_roll,
   output logic signed [PITCH_W-1:0] rsp_pitch,
   output logic signed [YAW_W-1:0]  rsp_yaw,
   output logic                     rsp_gimbal_lock,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [MARGIN_W-1:0]      csr_gimbal_margin
);

   localparam int DLY = 1 + SQRT_STAGES;

   logic en;
   logic [MARGIN_W-1:0] margin_ff;

   // stage 1: products
   logic v1_ff;
   logic signed [PROD_W-1:0] p_xx_ff, p_yy_ff, p_zz_ff, p_ww_ff, p_wy_ff, p_xz_ff;
   logic signed [PROD_W-1:0] p_xy_ff, p_wz_ff, p_wx_ff, p_yz_ff;
   // stage 2: sums
   logic v2_ff;
   logic signed [S_W-1:0]   s2_ff;
   logic signed [ARG_W-1:0] ya_y_ff, ya_x_ff, ro_y_ff, ro_x_ff, lk_y_ff, lk_x_ff;
   logic signed [ARG_W-1:0] diff_c;
   logic signed [SF_W-1:0]  s_full_c;
   logic signed [S_W-1:0]   s_clamp_c;
   // stage 3: radicand
   logic v3_ff;
   logic signed [S_W-1:0]    s3_ff;
   logic [SQ_N_W-1:0]        n3_ff;
   logic signed [2*S_W-1:0]  sq_c;
   // square root output
   logic              sq_valid;
   logic [ROOT_W-1:0] root;
   logic [S_W-1:0]    s_sq;
   // CORDIC outputs
   logic signed [ANG_W-1:0] pitch_z, yaw_z, roll_z, lock_z;
   logic                    pv_ff [0:CORDIC_STEPS];
   logic signed [ANG_W-1:0] yz_dl_ff [0:DLY-1];
   logic signed [ANG_W-1:0] rz_dl_ff [0:DLY-1];
   logic signed [ANG_W-1:0] lz_dl_ff [0:DLY-1];
   // branch select stage
   logic                    vl_ff, lock_ff, neg_ff;
   logic signed [Q12_W-1:0] p12_ff;
   logic signed [ANG_W-1:0] yz_ff, rz_ff, lz_ff;
   logic signed [Q12_W-1:0] p12_c, ap12_c;
   logic signed [Q12_W:0]   room_c;
   logic                    lock_c;
   // output
   logic                     out_v_ff, out_lock_ff;
   logic signed [ROLL_W-1:0] out_roll_ff;
   logic signed [PITCH_W-1:0] out_pitch_ff;
   logic signed [YAW_W-1:0]  out_yaw_ff;
   logic signed [ANG_W-1:0]  yaw_a_c, roll_a_c;
   logic signed [Q12_W-1:0]  yaw12_c, roll12_c;

   // advance whenever the output slot is free or being taken
   assign en        = !out_v_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // hold the margin register
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else if (csr_valid) begin
         margin_ff <= csr_gimbal_margin;
      end
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // register the pairwise products
   always_ff @(posedge clock) begin
      if (en) begin
         p_xx_ff <= PROD_W'(req_quat_x) * PROD_W'(req_quat_x);
         p_yy_ff <= PROD_W'(req_quat_y) * PROD_W'(req_quat_y);
         p_zz_ff <= PROD_W'(req_quat_z) * PROD_W'(req_quat_z);
         p_ww_ff <= PROD_W'(req_quat_w) * PROD_W'(req_quat_w);
         p_wy_ff <= PROD_W'(req_quat_w) * PROD_W'(req_quat_y);
         p_xz_ff <= PROD_W'(req_quat_x) * PROD_W'(req_quat_z);
         p_xy_ff <= PROD_W'(req_quat_x) * PROD_W'(req_quat_y);
         p_wz_ff <= PROD_W'(req_quat_w) * PROD_W'(req_quat_z);
         p_wx_ff <= PROD_W'(req_quat_w) * PROD_W'(req_quat_x);
         p_yz_ff <= PROD_W'(req_quat_y) * PROD_W'(req_quat_z);
      end
   end

   // scale the asin argument to 30 fraction bits and clamp it to one
   always_comb begin
      diff_c   = ARG_W'(p_wy_ff) - ARG_W'(p_xz_ff);
      s_full_c = SF_W'(diff_c) <<< 1;
      s_full_c = (s_full_c <<< SCALE_UP) >>> SCALE_DN;
      if (s_full_c > (SF_W'(1) <<< 30)) begin
         s_clamp_c = S_W'(1) <<< 30;
      end else if (s_full_c < -(SF_W'(1) <<< 30)) begin
         s_clamp_c = -(S_W'(1) <<< 30);
      end else begin
         s_clamp_c = S_W'(s_full_c);
      end
   end

   // register the atan2 arguments
   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff   <= s_clamp_c;
         ya_y_ff <= (ARG_W'(p_xy_ff) + ARG_W'(p_wz_ff)) <<< 1;
         ya_x_ff <= ARG_W'(p_xx_ff) - ARG_W'(p_yy_ff) - ARG_W'(p_zz_ff) + ARG_W'(p_ww_ff);
         ro_y_ff <= (ARG_W'(p_wx_ff) + ARG_W'(p_yz_ff)) <<< 1;
         ro_x_ff <= ARG_W'(p_ww_ff) - ARG_W'(p_xx_ff) - ARG_W'(p_yy_ff) + ARG_W'(p_zz_ff);
         lk_y_ff <= (ARG_W'(p_yz_ff) - ARG_W'(p_wx_ff)) <<< 1;
         lk_x_ff <= (ARG_W'(p_xz_ff) + ARG_W'(p_wy_ff)) <<< 1;
      end
   end

   // radicand 2^60 - s^2
   assign sq_c = (2*S_W)'(s2_ff) * (2*S_W)'(s2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= s2_ff;
         n3_ff <= (SQ_N_W'(1) << 60) - SQ_N_W'(sq_c);
      end
   end

   qte_isqrt #(
      .SIDE_W (S_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .n_in      (n3_ff),
      .side_in   (s3_ff),
      .out_valid (sq_valid),
      .root_out  (root),
      .side_out  (s_sq)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock),
      .en    (en),
      .y_in  (XY_W'($signed(s_sq))),
      .x_in  (XY_W'($signed({1'b0, root}))),
      .z_out (pitch_z)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock (clock),
      .en    (en),
      .y_in  (XY_W'(ya_y_ff)),
      .x_in  (XY_W'(ya_x_ff)),
      .z_out (yaw_z)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock (clock),
      .en    (en),
      .y_in  (XY_W'(ro_y_ff)),
      .x_in  (XY_W'(ro_x_ff)),
      .z_out (roll_z)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_lock (
      .clock (clock),
      .en    (en),
      .y_in  (XY_W'(lk_y_ff)),
      .x_in  (XY_W'(lk_x_ff)),
      .z_out (lock_z)
   );

   // carry valid through the pitch CORDIC
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            pv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         pv_ff[0] <= sq_valid;
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            pv_ff[i] <= pv_ff[i-1];
         end
      end
   end

   // delay roll/yaw angles to line up with pitch
   always_ff @(posedge clock) begin
      if (en) begin
         yz_dl_ff[0] <= yaw_z;
         rz_dl_ff[0] <= roll_z;
         lz_dl_ff[0] <= lock_z;
         for (int i = 1; i < DLY; i++) begin
            yz_dl_ff[i] <= yz_dl_ff[i-1];
            rz_dl_ff[i] <= rz_dl_ff[i-1];
            lz_dl_ff[i] <= lz_dl_ff[i-1];
         end
      end
   end

   // decide the singular branch
   always_comb begin
      p12_c  = to_q12(pitch_z);
      ap12_c = (p12_c < 0) ? -p12_c : p12_c;
      room_c = (Q12_W+1)'(HALF_PI_Q12) - (Q12_W+1)'(ap12_c);
      lock_c = room_c <= $signed((Q12_W+1)'(margin_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= 1'b0;
      end else if (en) begin
         vl_ff <= pv_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lock_ff <= lock_c;
         neg_ff  <= pitch_z < 0;
         p12_ff  <= p12_c;
         yz_ff   <= yz_dl_ff[DLY-1];
         rz_ff   <= rz_dl_ff[DLY-1];
         lz_ff   <= lz_dl_ff[DLY-1];
      end
   end

   // pick the branch angles and round
   always_comb begin
      if (lock_ff) begin
         yaw_a_c  = neg_ff ? (ANG_PI - lz_ff) : lz_ff;
         roll_a_c = '0;
      end else begin
         yaw_a_c  = yz_ff;
         roll_a_c = rz_ff;
      end
      yaw12_c  = to_q12(yaw_a_c);
      roll12_c = to_q12(roll_a_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= vl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_lock_ff  <= lock_ff;
         out_pitch_ff <= p12_ff[PITCH_W-1:0];
         out_roll_ff  <= roll12_c[ROLL_W-1:0];
         out_yaw_ff   <= yaw12_c[YAW_W-1:0];
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_roll        = out_roll_ff;
   assign rsp_pitch       = out_pitch_ff;
   assign rsp_yaw         = out_yaw_ff;
   assign rsp_gimbal_lock = out_lock_ff;

endmodule

[src/qte_checker.sv]
// Port-level assertions for quaternion_to_euler_top, bound to every instance.
// Depends on qte_pkg for field widths.
`timescale 1ns / 1ps
module qte_checker import qte_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [ROLL_W-1:0] rsp_roll,
   input logic                     rsp_gimbal_lock
);

   // a stalled result transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // while the output is stalled the pipeline takes no new transaction
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req_ready high while output stalled");

   // the singular branch forces roll to zero
   a_lock_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal_lock |-> rsp_roll == '0)
      else $error("roll nonzero in gimbal lock");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind quaternion_to_euler_top qte_checker u_qte_checker (.*);
